// ----- design/wdc_pkg.sv -----
// ----------------------------------------------------------------------------
// wdc_pkg
// Shared codes, controller states and control structures for the word
// dictionary.
// ----------------------------------------------------------------------------
`default_nettype none

package wdc_pkg;

   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [2:0] ST_UPDATED   = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_EMPTY     = 3'd5;

   localparam int ADDR_W = 16;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic slot_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ----- design/wdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// wdc_ctrl
// Sequencer: accept a transaction, run the table scan, post the result.
// ----------------------------------------------------------------------------
`default_nettype none

module wdc_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire wdc_pkg::ctrl_status_type stat,
   output wdc_pkg::ctrl_cmd_type         cmd
);

   wdc_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wdc_pkg::S_IDLE: begin
            if (req_tvalid) state_in = wdc_pkg::S_SCAN;
         end
         wdc_pkg::S_SCAN: begin
            if (stat.scan_done) state_in = wdc_pkg::S_FINISH;
         end
         wdc_pkg::S_FINISH: begin
            if (stat.slot_free) state_in = wdc_pkg::S_IDLE;
         end
         default: state_in = wdc_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wdc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == wdc_pkg::S_IDLE);
   assign cmd.load   = req_tready && req_tvalid;
   assign cmd.scan   = (state_ff == wdc_pkg::S_SCAN);
   assign cmd.finish = (state_ff == wdc_pkg::S_FINISH) && stat.slot_free;

endmodule

`default_nettype wire

// ----- design/wdc_datapath.sv -----
// ----------------------------------------------------------------------------
// wdc_datapath
// Key and address memories, scan pointer, compare stage and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wdc_datapath #(
   parameter int TABLE_ENTRIES = 64,
   parameter int WORD_CHARS    = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [79:0]              req_tdata,
   input  wire logic                     req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [15:0]                   rsp_tdata,
   output logic [2:0]                    rsp_tuser,
   input  wire wdc_pkg::ctrl_cmd_type    cmd,
   output wdc_pkg::ctrl_status_type      stat
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int KEY_W = 8 * WORD_CHARS;

   logic [KEY_W-1:0]           key_mem [TABLE_ENTRIES];
   logic [wdc_pkg::ADDR_W-1:0] addr_mem [TABLE_ENTRIES];

   logic [KEY_W-1:0]           key_ff, key_in;
   logic                       empty_ff, op_ff;
   logic [wdc_pkg::ADDR_W-1:0] addr_ff;
   logic [CNT_W-1:0]           idx_ff, count_ff;
   logic [KEY_W-1:0]           rd_key_ff;
   logic [wdc_pkg::ADDR_W-1:0] rd_addr_ff;
   logic [IDX_W-1:0]           rd_idx_ff;
   logic                       rd_valid_ff;
   logic                       hit_ff;
   logic [IDX_W-1:0]           hit_idx_ff;
   logic [wdc_pkg::ADDR_W-1:0] hit_addr_ff;
   logic                       rsp_valid_ff;
   logic [2:0]                 rsp_status_ff, status_in;
   logic [wdc_pkg::ADDR_W-1:0] rsp_addr_ff, found_in;

   logic more, issue, match, room, do_update, do_insert;

   // key ends at its first zero character
   always_comb begin
      logic alive;
      alive  = 1'b1;
      key_in = '0;
      for (int i = 0; i < WORD_CHARS; i++) begin
         if (req_tdata[8*i +: 8] == 8'd0) alive = 1'b0;
         if (alive) key_in[8*i +: 8] = req_tdata[8*i +: 8];
      end
   end

   assign more  = (idx_ff < count_ff);
   assign issue = cmd.scan && !empty_ff && !hit_ff && more;
   assign match = rd_valid_ff && (rd_key_ff == key_ff);
   assign room  = (count_ff < CNT_W'(TABLE_ENTRIES));

   assign do_update = cmd.finish && !empty_ff && (op_ff == wdc_pkg::OP_ADD) && hit_ff;
   assign do_insert = cmd.finish && !empty_ff && (op_ff == wdc_pkg::OP_ADD) && !hit_ff
                      && room;

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_key_ff  <= key_mem[idx_ff[IDX_W-1:0]];
         rd_addr_ff <= addr_mem[idx_ff[IDX_W-1:0]];
      end
      if (do_insert) begin
         key_mem[count_ff[IDX_W-1:0]] <= key_ff;
      end
      if (do_update) begin
         addr_mem[hit_idx_ff] <= addr_ff;
      end else if (do_insert) begin
         addr_mem[count_ff[IDX_W-1:0]] <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff   <= key_in;
         empty_ff <= (req_tdata[7:0] == 8'd0);
         op_ff    <= req_tuser;
         addr_ff  <= req_tdata[79:64];
      end
      if (issue) rd_idx_ff <= idx_ff[IDX_W-1:0];
      if (match) begin
         hit_idx_ff  <= rd_idx_ff;
         hit_addr_ff <= rd_addr_ff;
      end
      if (cmd.finish) begin
         rsp_status_ff <= status_in;
         rsp_addr_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
         end else if (issue) begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
         rd_valid_ff <= issue;
         if (cmd.load) begin
            hit_ff <= 1'b0;
         end else if (match) begin
            hit_ff <= 1'b1;
         end
         if (do_insert) count_ff <= count_ff + CNT_W'(1);
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      found_in = '0;
      if (empty_ff) begin
         status_in = wdc_pkg::ST_EMPTY;
      end else if (op_ff == wdc_pkg::OP_LOOKUP) begin
         if (hit_ff) begin
            status_in = wdc_pkg::ST_FOUND;
            found_in  = hit_addr_ff;
         end else begin
            status_in = wdc_pkg::ST_NOT_FOUND;
         end
      end else if (hit_ff) begin
         status_in = wdc_pkg::ST_UPDATED;
      end else if (room) begin
         status_in = wdc_pkg::ST_INSERTED;
      end else begin
         status_in = wdc_pkg::ST_FULL;
      end
   end

   assign stat.scan_done = empty_ff || hit_ff || (!more && !rd_valid_ff);
   assign stat.slot_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// ----- design/word_dictionary_cam.sv -----
// ----------------------------------------------------------------------------
// word_dictionary_cam
// Associative word dictionary: add/redefine and look up packed word keys.
//
//   channel  dir  tdata                                  tuser
//   req      in   [63:0] word_key, [79:64] start_address [0] opcode
//   rsp      out  [15:0] found_address                   [2:0] status
//
// One transaction at a time. A transaction is accepted, then the scan reads
// one held entry per memory read and compares it (read register, then the
// compare into the hit flag) until a hit or the last entry, and the result
// is posted; the empty word skips the scan.
// Reset clears the entry count; the memories need no clearing pass.
// The result register lets a new request be taken while rsp is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module word_dictionary_cam #(
   parameter int TABLE_ENTRIES = 64,
   parameter int WORD_CHARS    = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // word_key, start_address
   input  wire logic        req_tuser,   // opcode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // found_address
   output logic [2:0]       rsp_tuser    // status
);

   wdc_pkg::ctrl_cmd_type    cmd;
   wdc_pkg::ctrl_status_type stat;

   wdc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wdc_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .WORD_CHARS    (WORD_CHARS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

   a_finish_after_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> stat.scan_done)
      else $error("result posted before scan completed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a transaction is in progress");

   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_tvalid)
      else $error("finished transaction produced no result");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= wdc_pkg::ST_EMPTY))
      else $error("undefined status code");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != wdc_pkg::ST_FOUND)) |-> (rsp_tdata == 16'd0))
      else $error("address non-zero on a miss");

endmodule

`default_nettype wire

// ----- tb/word_dictionary_cam_tb.sv -----
// ----------------------------------------------------------------------------
// word_dictionary_cam_tb
// Self-checking bench for the word dictionary. Add and lookup transactions
// go in on req; a local copy of the dictionary predicts each status and
// address, and rsp transactions are checked in order against that copy.
// Directed cases cover the empty word, tails after the terminator and the
// full table, with random traffic before and after it. Idle gaps on both
// channels and one long rsp hold-off are also exercised.
// ----------------------------------------------------------------------------
module word_dictionary_cam_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DICT_DEPTH     = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 80;
   localparam int HOLD_OFF       = 300;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] address;
   } dict_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // word_key, start_address
   logic        req_tuser = 1'b0; // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // found_address
   logic [2:0]  rsp_tuser;        // status

   logic [63:0] dict_key  [DICT_DEPTH];
   logic [15:0] dict_addr [DICT_DEPTH];
   int          dict_count = 0;

   dict_reply_type expected_replies[$];
   int          status_hits [8];
   int          requests_sent = 0;
   int          replies_seen = 0;
   int          mismatches = 0;
   int          idle_cycles = 0;
   bit          req_idle_en = 1'b1;
   bit          rsp_idle_en = 1'b1;
   int          hold_off_req = 0;
   int          hold_left = 0;
   int          stall_left = 0;

   word_dictionary_cam DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // characters up to the first zero byte
   function automatic logic [63:0] trim_key(input logic [63:0] raw);
      logic [63:0] key;
      bit          ended;
      int          i;
      key = '0;
      ended = 1'b0;
      for (i = 0; i < 8; i++) begin
         if (raw[8*i +: 8] == 8'h00) ended = 1'b1;
         if (!ended) key[8*i +: 8] = raw[8*i +: 8];
      end
      return key;
   endfunction

   // fresh word of 1..8 non-zero characters, zero padded
   function automatic logic [63:0] make_word();
      logic [63:0] word;
      int          len;
      int          i;
      word = '0;
      len = $urandom_range(1, 8);
      for (i = 0; i < len; i++) word[8*i +: 8] = 8'($urandom_range(1, 255));
      return word;
   endfunction

   // same word, sometimes with garbage after the terminator
   function automatic logic [63:0] dress_key(input logic [63:0] word);
      logic [63:0] raw;
      int          len;
      int          i;
      raw = word;
      len = 0;
      for (i = 0; i < 8; i++) if (word[8*i +: 8] != 8'h00 && len == i) len = i + 1;
      if (len < 8 && $urandom_range(0, 1) == 1) begin
         raw = {$urandom, $urandom};
         raw[8*len +: 8] = 8'h00;
         for (i = 0; i < len; i++) raw[8*i +: 8] = word[8*i +: 8];
      end
      return raw;
   endfunction

   function automatic dict_reply_type predict_reply(input logic op, input logic [63:0] raw,
                                                    input logic [15:0] addr);
      dict_reply_type reply;
      logic [63:0] key;
      int          hit;
      int          i;
      key = trim_key(raw);
      hit = -1;
      reply.address = '0;
      for (i = 0; i < dict_count; i++) if (hit < 0 && dict_key[i] == key) hit = i;
      if (key == '0) begin
         reply.status = wdc_pkg::ST_EMPTY;
      end else if (op == wdc_pkg::OP_LOOKUP) begin
         if (hit >= 0) begin
            reply.status = wdc_pkg::ST_FOUND;
            reply.address = dict_addr[hit];
         end else begin
            reply.status = wdc_pkg::ST_NOT_FOUND;
         end
      end else if (hit >= 0) begin
         dict_addr[hit] = addr;
         reply.status = wdc_pkg::ST_UPDATED;
      end else if (dict_count >= DICT_DEPTH) begin
         reply.status = wdc_pkg::ST_FULL;
      end else begin
         dict_key[dict_count] = key;
         dict_addr[dict_count] = addr;
         dict_count++;
         reply.status = wdc_pkg::ST_INSERTED;
      end
      return reply;
   endfunction

   task automatic send_request(input logic op, input logic [63:0] raw,
                               input logic [15:0] addr);
      dict_reply_type reply;
      int          gap;
      gap = req_idle_en ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {addr, raw};
      req_tuser <= op;
      do @(posedge clock); while (req_tready !== 1'b1);
      reply = predict_reply(op, raw, addr);
      expected_replies.push_back(reply);
      status_hits[reply.status]++;
      requests_sent++;
   endtask

   task automatic flag_mismatch(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on reply %0d, %s: expected %h, got %h", replies_seen, what, want, got);
   endtask

   // rsp side: random stalls plus the long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_off_req > 0) begin
            hold_left = hold_off_req;
            hold_off_req = 0;
         end
         if (hold_left == 0 && stall_left == 0 && rsp_idle_en) stall_left = pick_gap();
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      dict_reply_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         replies_seen++;
         if (expected_replies.size() == 0) begin
            flag_mismatch("no transaction pending, status/address", '0,
                          {rsp_tuser[2:0], rsp_tdata[12:0]});
         end else begin
            want = expected_replies.pop_front();
            if (rsp_tuser !== want.status) flag_mismatch("status", want.status, rsp_tuser);
            if (rsp_tdata !== want.address) flag_mismatch("address", want.address, rsp_tdata);
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transaction for %0d cycles, %0d replies outstanding",
               WATCHDOG_LIMIT, expected_replies.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic test_empty_word();
      send_request(wdc_pkg::OP_LOOKUP, 64'h0, 16'h0000);
      send_request(wdc_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FF00, 16'hFFFF);
      send_request(wdc_pkg::OP_LOOKUP, 64'h0000_0000_0000_0041, 16'hFFFF);
   endtask

   task automatic test_insert_lookup();
      send_request(wdc_pkg::OP_ADD, 64'h0000_0000_0000_0041, 16'h0000);
      send_request(wdc_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
      send_request(wdc_pkg::OP_ADD, 64'h0101_0101_0101_0101, 16'h5AA5);
      send_request(wdc_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);
      send_request(wdc_pkg::OP_LOOKUP, 64'h0000_0000_0000_0041, 16'h0000);
      send_request(wdc_pkg::OP_LOOKUP, 64'h0101_0101_0101_0101, 16'h0000);
      send_request(wdc_pkg::OP_LOOKUP, 64'h0000_0000_0000_4241, 16'h0000);
   endtask

   task automatic test_redefine();
      send_request(wdc_pkg::OP_ADD, 64'h0000_0000_0000_0041, 16'hFFFF);
      send_request(wdc_pkg::OP_LOOKUP, 64'h0000_0000_0000_0041, 16'h0000);
      send_request(wdc_pkg::OP_ADD, 64'h0000_0000_0000_4241, 16'h1234);
      send_request(wdc_pkg::OP_LOOKUP, 64'h0000_0000_0000_4241, 16'h0000);
   endtask

   task automatic test_key_tail();
      send_request(wdc_pkg::OP_LOOKUP, 64'hDEAD_BEEF_CAFE_0041, 16'h0000);
      send_request(wdc_pkg::OP_ADD, 64'h5A5A_5A5A_5A00_4241, 16'h8001);
      send_request(wdc_pkg::OP_LOOKUP, 64'hA5A5_A5A5_A500_4241, 16'h0000);
   endtask

   task automatic random_traffic(input int count);
      logic [63:0] word;
      logic [63:0] raw;
      int          n;
      int          pick;
      for (n = 0; n < count; n++) begin
         if (n % 40 == 0) begin
            req_idle_en = ($urandom_range(0, 3) != 0);
            rsp_idle_en = ($urandom_range(0, 3) != 0);
         end
         pick = $urandom_range(0, 99);
         word = make_word();
         if (dict_count > 0 && pick >= 25 && pick < 80)
            word = dict_key[$urandom_range(0, dict_count - 1)];
         if (pick < 45) begin
            send_request(wdc_pkg::OP_ADD, dress_key(word), 16'($urandom));
         end else if (pick < 90) begin
            send_request(wdc_pkg::OP_LOOKUP, dress_key(word), 16'($urandom));
         end else begin
            raw = {$urandom, $urandom};
            if ($urandom_range(0, 2) == 0) raw[7:0] = 8'h00;
            send_request(1'($urandom_range(0, 1)), raw, 16'($urandom));
         end
      end
   endtask

   task automatic test_random_growth();
      random_traffic(250);
   endtask

   task automatic test_backpressure();
      int n;
      req_idle_en = 1'b0;
      hold_off_req = HOLD_OFF;
      for (n = 0; n < 12; n++) begin
         if (n % 2 == 0 && dict_count > 0)
            send_request(wdc_pkg::OP_LOOKUP, dict_key[$urandom_range(0, dict_count - 1)],
                         16'h0000);
         else
            send_request(wdc_pkg::OP_ADD, make_word(), 16'($urandom));
      end
      req_idle_en = 1'b1;
   endtask

   task automatic test_table_full();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      while (dict_count < DICT_DEPTH)
         send_request(wdc_pkg::OP_ADD, dress_key(make_word()), 16'($urandom));
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      send_request(wdc_pkg::OP_ADD, 64'h0000_0000_0000_0000, 16'hBEEF);
      send_request(wdc_pkg::OP_ADD, 64'h7E7E_7E7E_7E7E_7E7E, 16'hBEEF);
      send_request(wdc_pkg::OP_ADD, 64'h0000_0000_007E_7E7E, 16'h0F0F);
      send_request(wdc_pkg::OP_ADD, dict_key[DICT_DEPTH - 1], 16'hC3C3);
      send_request(wdc_pkg::OP_ADD, dress_key(dict_key[0]), 16'h3C3C);
      send_request(wdc_pkg::OP_LOOKUP, dress_key(dict_key[DICT_DEPTH - 1]), 16'h0000);
      send_request(wdc_pkg::OP_LOOKUP, 64'h7E7E_7E7E_7E7E_7E7E, 16'h0000);
   endtask

   task automatic test_random_full();
      random_traffic(270);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_empty_word();
      test_insert_lookup();
      test_redefine();
      test_key_tail();
      test_random_growth();
      test_backpressure();
      test_table_full();
      test_random_full();
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d requests: %0d inserted, %0d updated, %0d found, %0d not found",
               requests_sent, status_hits[wdc_pkg::ST_INSERTED],
               status_hits[wdc_pkg::ST_UPDATED], status_hits[wdc_pkg::ST_FOUND],
               status_hits[wdc_pkg::ST_NOT_FOUND]);
      $display("%0d refused on a full table, %0d empty words, %0d of %0d entries held",
               status_hits[wdc_pkg::ST_FULL], status_hits[wdc_pkg::ST_EMPTY], dict_count,
               DICT_DEPTH);
      $display("%0d mismatches", mismatches);
      if (mismatches == 0 && expected_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
